@@ hw/rtl/s2i_pkg.sv @@
// Shared types, constants and helper functions for the string to signed
// 64-bit parser. Used by the top level and by the multiply-add unit.
`default_nettype none

package s2i_pkg;

  // Longest string position that is tracked; positions saturate at MAX_LEN-1.
  localparam int MAX_LEN = 4096;
  localparam int POS_W   = $clog2(MAX_LEN);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN - 1);

  // Field widths fixed by the interface.
  localparam int CHAR_W  = 8;
  localparam int RADIX_W = 6;
  localparam int VALUE_W = 64;
  localparam int CNT_W   = 12;
  localparam int DIGIT_W = 6;

  // Digit value of a character that is neither a digit nor a letter.
  localparam logic [DIGIT_W-1:0] NOT_DIGIT = DIGIT_W'(36);

  // Radix codes.
  localparam logic [RADIX_W-1:0] RADIX_AUTO = RADIX_W'(0);
  localparam logic [RADIX_W-1:0] RADIX_ONE  = RADIX_W'(1);
  localparam logic [RADIX_W-1:0] RADIX_BIN  = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_OCT  = RADIX_W'(8);
  localparam logic [RADIX_W-1:0] RADIX_DEC  = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_HEX  = RADIX_W'(16);
  localparam logic [RADIX_W-1:0] RADIX_MAX  = RADIX_W'(36);

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_B  = 8'h42;
  localparam logic [CHAR_W-1:0] CH_UC_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_B  = 8'h62;
  localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_RANGE     = 2'd1,
    STAT_BAD_RADIX = 2'd2,
    STAT_NO_DIGITS = 2'd3
  } status_t;

  // One input transaction.
  typedef struct packed {
    logic [CHAR_W-1:0]  character;
    logic               first_char;
    logic [RADIX_W-1:0] radix;
  } s2i_in_t;

  // One result transaction.
  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    status_t                   status;
    logic [CNT_W-1:0]          consumed_count;
  } s2i_out_t;

  // Digit value of a character: 0-9 for decimal digits, 10-35 for letters.
  function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = DIGIT_W'(c - CH_ZERO);
    end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
      d = DIGIT_W'(c - CH_UC_A + 8'd10);
    end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
      d = DIGIT_W'(c - CH_LC_A + 8'd10);
    end else begin
      d = NOT_DIGIT;
    end
    return d;
  endfunction

  // Whitespace: space, tab, line feed, vertical tab, form feed, carriage return.
  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/s2i_mac.sv @@
// Multiply-add unit of the parser: accum * radix + digit with unsigned
// 64-bit overflow detection. Depends on s2i_pkg.
`default_nettype none

module s2i_mac (
  input  wire logic [s2i_pkg::VALUE_W-1:0] accum,
  input  wire logic [s2i_pkg::RADIX_W-1:0] radix,
  input  wire logic [s2i_pkg::DIGIT_W-1:0] digit,
  output logic      [s2i_pkg::VALUE_W-1:0] sum,
  output logic                             ovf
);
  import s2i_pkg::*;

  localparam int FULL_W = VALUE_W + RADIX_W;

  logic [FULL_W-1:0] full;

  // The new value fits in 64 bits exactly when no bit above bit 63 is set.
  assign full = (FULL_W'(accum) * FULL_W'(radix)) + FULL_W'(digit);
  assign sum  = full[VALUE_W-1:0];
  assign ovf  = |full[FULL_W-1:VALUE_W];

endmodule

`default_nettype wire

@@ hw/rtl/string_to_signed64_parser_unit.sv @@
// Top level of the streaming string to signed 64-bit integer parser.
// Depends on s2i_pkg and s2i_mac.
`default_nettype none

// The parser takes one string character per input transaction and gives one
// result transaction on the character that ends the number (strtoll rules:
// leading whitespace, optional sign, 0x/0b/octal detection with radix 0,
// letters as digits 10-35, saturation to the signed 64-bit limit). A
// transaction with first_char set starts a new string at any time and samples
// the radix; a bad radix answers at once on that character. Characters that
// arrive while no string is open are dropped silently. The unit takes one
// character every clock cycle unless a waiting result holds the input
// register. The character that ends the number is first captured in the
// input register, and its result is captured in the result register when
// the input register advances, which raises out_valid. The cycle is set by
// the 64 by 6 bit multiply-add with its overflow check. A waiting result
// stalls the pipeline only when the input register is also occupied.
module string_to_signed64_parser_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire s2i_pkg::s2i_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output s2i_pkg::s2i_out_t      out_data
);
  import s2i_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_LEAD   = 6'b000010,
    PH_SIGNED = 6'b000100,
    PH_ZERO   = 6'b001000,
    PH_PREFIX = 6'b010000,
    PH_DIGITS = 6'b100000
  } phase_t;

  // Input register and result register.
  logic     stg_valid_r;
  s2i_in_t  stg_data_r;
  logic     out_valid_r;
  s2i_out_t out_data_r;

  // Parse state.
  phase_t              phase_r, phase_nxt;
  logic [VALUE_W-1:0]  accum_r, accum_nxt;
  logic                ovf_r, ovf_nxt;
  logic                neg_r, neg_nxt;
  logic [RADIX_W-1:0]  radix_r, radix_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [POS_W-1:0]    zpos_r, zpos_nxt;

  // State seen by the current character, after a possible restart.
  phase_t              cur_phase;
  logic [VALUE_W-1:0]  cur_accum;
  logic                cur_ovf;
  logic                cur_neg;
  logic [RADIX_W-1:0]  cur_radix;
  logic [POS_W-1:0]    cur_pos;
  logic [POS_W-1:0]    cur_zpos;

  logic                advance;
  logic                bad_radix;
  logic [CHAR_W-1:0]   ch;
  logic [DIGIT_W-1:0]  dig;
  logic [RADIX_W-1:0]  eff_radix;
  logic [RADIX_W-1:0]  first_radix;
  logic [RADIX_W-1:0]  mac_radix;
  logic [VALUE_W-1:0]  mac_sum;
  logic                mac_ovf;
  logic [VALUE_W-1:0]  limit;
  logic                first_digit;
  logic                run_digit;
  logic                emit;
  s2i_out_t            res;

  // Handshake: the input register moves on whenever the result register can take.
  assign advance   = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !stg_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ch  = stg_data_r.character;
  assign dig = digit_value(ch);

  assign bad_radix = stg_data_r.first_char &&
                     (stg_data_r.radix == RADIX_ONE || stg_data_r.radix > RADIX_MAX);

  // A first character clears the state and loads the requested radix.
  always_comb begin
    if (stg_data_r.first_char) begin
      cur_phase = PH_LEAD;
      cur_accum = '0;
      cur_ovf   = 1'b0;
      cur_neg   = 1'b0;
      cur_radix = stg_data_r.radix;
      cur_pos   = '0;
      cur_zpos  = '0;
    end else begin
      cur_phase = phase_r;
      cur_accum = accum_r;
      cur_ovf   = ovf_r;
      cur_neg   = neg_r;
      cur_radix = radix_r;
      cur_pos   = pos_r;
      cur_zpos  = zpos_r;
    end
  end

  // Radix in force once digits start; auto after a leading zero means octal.
  assign eff_radix   = (cur_radix == RADIX_AUTO) ? RADIX_OCT : cur_radix;
  assign first_radix = (cur_radix == RADIX_AUTO) ? RADIX_DEC : cur_radix;
  assign mac_radix   = (eff_radix < RADIX_BIN) ? RADIX_DEC : eff_radix;

  // Signed limit for the sign: 2^63 when negative, 2^63-1 otherwise.
  assign limit = {cur_neg, {(VALUE_W-1){!cur_neg}}};

  s2i_mac u_mac (
    .accum (cur_accum),
    .radix (mac_radix),
    .digit (dig),
    .sum   (mac_sum),
    .ovf   (mac_ovf)
  );

  // Next state and result for the character in the input register.
  always_comb begin
    phase_nxt   = cur_phase;
    accum_nxt   = cur_accum;
    ovf_nxt     = cur_ovf;
    neg_nxt     = cur_neg;
    radix_nxt   = cur_radix;
    pos_nxt     = cur_pos;
    zpos_nxt    = cur_zpos;
    first_digit = 1'b0;
    run_digit   = 1'b0;
    emit        = 1'b0;
    res.result_value   = '0;
    res.status         = STAT_OK;
    res.consumed_count = '0;

    if (bad_radix) begin
      emit       = 1'b1;
      res.status = STAT_BAD_RADIX;
    end else if (cur_phase != PH_IDLE) begin
      unique case (cur_phase)
        PH_LEAD: begin
          if (is_space(ch)) begin
            phase_nxt = PH_LEAD;
          end else if (ch == CH_PLUS || ch == CH_MINUS) begin
            neg_nxt   = (ch == CH_MINUS);
            phase_nxt = PH_SIGNED;
          end else begin
            first_digit = 1'b1;
          end
        end
        PH_SIGNED: begin
          first_digit = 1'b1;
        end
        PH_ZERO: begin
          if ((ch == CH_LC_X || ch == CH_UC_X) &&
              (cur_radix == RADIX_AUTO || cur_radix == RADIX_HEX)) begin
            radix_nxt = RADIX_HEX;
            phase_nxt = PH_PREFIX;
          end else if ((ch == CH_LC_B || ch == CH_UC_B) &&
                       (cur_radix == RADIX_AUTO || cur_radix == RADIX_BIN)) begin
            radix_nxt = RADIX_BIN;
            phase_nxt = PH_PREFIX;
          end else begin
            run_digit = 1'b1;
          end
        end
        PH_PREFIX: begin
          if (dig < cur_radix) begin
            accum_nxt = VALUE_W'(dig);
            phase_nxt = PH_DIGITS;
          end else begin
            // A bare prefix: the number is the zero before the x or b.
            emit               = 1'b1;
            res.status         = STAT_OK;
            res.consumed_count = CNT_W'((cur_zpos == POS_MAX) ? POS_MAX
                                                              : cur_zpos + POS_W'(1));
          end
        end
        PH_DIGITS: begin
          run_digit = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase

      // First character after whitespace and sign.
      if (first_digit) begin
        if (ch == CH_ZERO) begin
          zpos_nxt  = cur_pos;
          phase_nxt = PH_ZERO;
        end else if (dig < first_radix) begin
          radix_nxt = first_radix;
          accum_nxt = VALUE_W'(dig);
          phase_nxt = PH_DIGITS;
        end else begin
          emit       = 1'b1;
          res.status = STAT_NO_DIGITS;
        end
      end

      // Digit accumulation, or the end of the number.
      if (run_digit) begin
        radix_nxt = eff_radix;
        phase_nxt = PH_DIGITS;
        if (dig < eff_radix) begin
          if (mac_ovf) begin
            ovf_nxt = 1'b1;
          end else begin
            accum_nxt = mac_sum;
          end
        end else begin
          emit               = 1'b1;
          res.consumed_count = CNT_W'(cur_pos);
          if (cur_ovf || cur_accum > limit) begin
            res.result_value = $signed(limit);
            res.status       = STAT_RANGE;
          end else begin
            res.result_value = $signed(cur_neg ? (VALUE_W'(0) - cur_accum) : cur_accum);
            res.status       = STAT_OK;
          end
        end
      end

      pos_nxt = (cur_pos == POS_MAX) ? POS_MAX : cur_pos + POS_W'(1);
    end

    if (emit) begin
      phase_nxt = PH_IDLE;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_data_r <= in_data;
    end
  end

  // Parse state, updated once per character.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      accum_r <= '0;
      ovf_r   <= 1'b0;
      neg_r   <= 1'b0;
      radix_r <= '0;
      pos_r   <= '0;
      zpos_r  <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      ovf_r   <= ovf_nxt;
      neg_r   <= neg_nxt;
      radix_r <= radix_nxt;
      pos_r   <= pos_nxt;
      zpos_r  <= zpos_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data_r <= res;
    end
  end

endmodule

`default_nettype wire
